[rtl/ple_pkg.sv]
// Package for the positional list engine.
// Holds the list capacity, field widths, operation and status codes, and the state encoding.
// No dependencies.
package ple_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  localparam int unsigned OpW   = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 5;
  localparam int unsigned StW   = 3;

  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_INSERT_AT  = 3'd2;
  localparam logic [OpW-1:0] OP_DELETE_AT  = 3'd3;
  localparam logic [OpW-1:0] OP_COUNT      = 3'd4;
  localparam logic [OpW-1:0] OP_SEARCH     = 3'd5;
  localparam logic [OpW-1:0] OP_READ_AT    = 3'd6;

  localparam logic [StW-1:0] ST_OK      = 3'd0;
  localparam logic [StW-1:0] ST_EMPTY   = 3'd1;
  localparam logic [StW-1:0] ST_RANGE   = 3'd2;
  localparam logic [StW-1:0] ST_FULL    = 3'd3;
  localparam logic [StW-1:0] ST_MISSING = 3'd4;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_RD  = 8'b0000_0010,
    S_INS_WR  = 8'b0000_0100,
    S_INS_PUT = 8'b0000_1000,
    S_DEL_RD  = 8'b0001_0000,
    S_DEL_WR  = 8'b0010_0000,
    S_SRCH    = 8'b0100_0000,
    S_READ    = 8'b1000_0000
  } state_e;

endpackage

[rtl/ple_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth set by parameters; no dependencies.
module ple_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/positional_list_engine.sv]
// Positional list engine: bounded ordered list of signed 32-bit values.
// Count, unused-code, empty, full and range requests, appends and deletes of the last entry
// strobe their result in the cycle after accept; read at passes through S_READ, search scans
// entries in order, other inserts shift entries up then write the item, other deletes shift down.
// busy drops in the strobe cycle, so the next request is taken at the edge that ends it.
// Cost is set by the RAM's one read and one write port that every shift and scan step uses.
// Reset clears the state, entry count and result strobe; list storage is never cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module positional_list_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ple_pkg::OpW-1:0]      operation_i,
  input  logic signed [ple_pkg::DataW-1:0] item_value_i,
  input  logic [ple_pkg::PosW-1:0]     position_i,
  output logic                         result_valid_o,
  output logic [ple_pkg::StW-1:0]      status_o,
  output logic [ple_pkg::CntW-1:0]     entry_count_o,
  output logic [ple_pkg::PosW-1:0]     found_position_o,
  output logic signed [ple_pkg::DataW-1:0] read_value_o
);
  import ple_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [DataW-1:0] value_q, value_d;

  logic             valid_q, valid_d;
  logic [StW-1:0]   status_q, status_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [PosW-1:0]  found_q, found_d;
  logic [DataW-1:0] readv_q, readv_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [DataW-1:0] wdata, rdata;

  logic             full, empty, pos_in_list, ins_pos_ok;
  logic [AddrW-1:0] pos_idx, len_idx;
  logic [CntW-1:0]  len_m1;

  assign full        = (len_q >= CntW'(Capacity));
  assign empty       = (len_q == '0);
  assign pos_in_list = (position_i != '0) && (CntW'(position_i) <= len_q);
  assign ins_pos_ok  = (position_i == PosW'(1)) || pos_in_list;
  assign pos_idx     = AddrW'(position_i - PosW'(1));
  assign len_idx     = AddrW'(len_q);
  assign len_m1      = len_q - CntW'(1);

  ple_ram #(
    .Width(DataW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    k_d      = k_q;
    idx_d    = idx_q;
    value_d  = value_q;
    valid_d  = 1'b0;
    status_d = status_q;
    count_d  = count_q;
    found_d  = found_q;
    readv_d  = readv_q;
    we       = 1'b0;
    waddr    = k_q;
    wdata    = rdata;
    raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          value_d  = item_value_i;
          status_d = ST_OK;
          count_d  = len_q;
          found_d  = '0;
          readv_d  = '0;
          unique case (operation_i) inside
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
              if (full) begin
                status_d = ST_FULL;
                valid_d  = 1'b1;
              end else if (operation_i == OP_INSERT_AT && !ins_pos_ok) begin
                status_d = ST_RANGE;
                valid_d  = 1'b1;
              end else begin
                if (operation_i == OP_PUSH_BACK) begin
                  idx_d = len_idx;
                end else if (operation_i == OP_PUSH_FRONT) begin
                  idx_d = '0;
                end else begin
                  idx_d = pos_idx;
                end
                if (idx_d == len_idx) begin
                  we      = 1'b1;
                  waddr   = idx_d;
                  wdata   = item_value_i;
                  len_d   = len_q + CntW'(1);
                  count_d = len_d;
                  valid_d = 1'b1;
                end else begin
                  k_d     = len_idx;
                  state_d = S_INS_RD;
                end
              end
            end
            OP_DELETE_AT: begin
              if (empty) begin
                status_d = ST_EMPTY;
                valid_d  = 1'b1;
              end else if (!pos_in_list) begin
                status_d = ST_RANGE;
                valid_d  = 1'b1;
              end else if (CntW'(pos_idx) == len_m1) begin
                len_d   = len_m1;
                count_d = len_m1;
                valid_d = 1'b1;
              end else begin
                k_d     = pos_idx;
                state_d = S_DEL_RD;
              end
            end
            OP_COUNT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end
              valid_d = 1'b1;
            end
            OP_SEARCH: begin
              if (empty) begin
                status_d = ST_EMPTY;
                valid_d  = 1'b1;
              end else begin
                raddr   = '0;
                k_d     = '0;
                state_d = S_SRCH;
              end
            end
            OP_READ_AT: begin
              if (empty) begin
                status_d = ST_EMPTY;
                valid_d  = 1'b1;
              end else if (!pos_in_list) begin
                status_d = ST_RANGE;
                valid_d  = 1'b1;
              end else begin
                raddr   = pos_idx;
                state_d = S_READ;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        raddr   = k_q - AddrW'(1);
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = rdata;
        k_d   = k_q - AddrW'(1);
        if (k_d == idx_q) begin
          state_d = S_INS_PUT;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_INS_PUT: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = value_q;
        len_d   = len_q + CntW'(1);
        count_d = len_d;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_DEL_RD: begin
        raddr   = k_q + AddrW'(1);
        state_d = S_DEL_WR;
      end
      S_DEL_WR: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = rdata;
        k_d   = k_q + AddrW'(1);
        if (CntW'(k_d) == len_m1) begin
          len_d   = len_m1;
          count_d = len_m1;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      S_SRCH: begin
        if (rdata == value_q) begin
          found_d = PosW'(k_q) + PosW'(1);
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (CntW'(k_q) == len_m1) begin
          status_d = ST_MISSING;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          k_d   = k_q + AddrW'(1);
          raddr = k_d;
        end
      end
      S_READ: begin
        readv_d = rdata;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    idx_q    <= idx_d;
    value_q  <= value_d;
    status_q <= status_d;
    count_q  <= count_d;
    found_q  <= found_d;
    readv_q  <= readv_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign entry_count_o    = count_q;
  assign found_position_o = found_q;
  assign read_value_o     = readv_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for positional_list_engine: a directed table, then biased random requests.
// A shadow list predicts results but for typed table rows. Depends on ple_pkg and the engine RTL.
module tb_top;
  import ple_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED = 3'd7;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned CalmTail    = 300;
  localparam int unsigned DrainCycles = 48;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct packed {
    logic [StW-1:0]          status;
    logic [CntW-1:0]         count;
    logic [PosW-1:0]         found;
    logic signed [DataW-1:0] value;
  } list_result_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] value;
    logic [PosW-1:0]  pos;
    logic             typed;
    list_result_t     want;
  } list_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [OpW-1:0]          operation_i;
  logic signed [DataW-1:0] item_value_i;
  logic [PosW-1:0]         position_i;
  logic                    result_valid_o;
  logic [StW-1:0]          status_o;
  logic [CntW-1:0]         entry_count_o;
  logic [PosW-1:0]         found_position_o;
  logic signed [DataW-1:0] read_value_o;

  logic [DataW-1:0] shadow_list [Capacity];
  int unsigned      shadow_len;
  list_result_t     pending_results [$];
  list_row_t        directed_rows [$];
  list_result_t     oldest_result;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned request_count;
  int unsigned hit_count;
  int unsigned full_count;
  int unsigned range_count;

  positional_list_engine i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .item_value_i     (item_value_i),
    .position_i       (position_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .entry_count_o    (entry_count_o),
    .found_position_o (found_position_o),
    .read_value_o     (read_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic list_result_t apply_list_op(input logic [OpW-1:0] op,
                                                 input logic [DataW-1:0] value,
                                                 input logic [PosW-1:0] pos);
    list_result_t res;
    int slot;
    int k;
    res  = '0;
    slot = 0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        if (shadow_len >= Capacity) begin
          res.status = ST_FULL;
        end else if (op == OP_INSERT_AT && !(pos == 1 || (pos > 1 && pos <= shadow_len))) begin
          res.status = ST_RANGE;
        end else begin
          if (op == OP_PUSH_FRONT) slot = 0;
          else if (op == OP_PUSH_BACK) slot = shadow_len;
          else slot = pos - 1;
          for (k = shadow_len; k > slot; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[slot] = value;
          shadow_len++;
        end
      end
      OP_DELETE_AT: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= 1 && pos <= shadow_len) begin
          for (k = pos - 1; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
          shadow_len--;
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_COUNT: begin
        if (shadow_len == 0) res.status = ST_EMPTY;
      end
      OP_SEARCH: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_MISSING;
          for (k = 0; k < shadow_len; k++) begin
            if (res.status == ST_MISSING && shadow_list[k] == value) begin
              res.status = ST_OK;
              res.found  = PosW'(k + 1);
            end
          end
        end
      end
      OP_READ_AT: begin
        if (shadow_len == 0) res.status = ST_EMPTY;
        else if (pos >= 1 && pos <= shadow_len) res.value = shadow_list[pos-1];
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    res.count = CntW'(shadow_len);
    return res;
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: return $urandom_range(0, 7) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [OpW-1:0] op, input logic [DataW-1:0] value,
                         input logic [PosW-1:0] pos, input logic typed,
                         input logic [StW-1:0] st, input logic [CntW-1:0] cnt,
                         input logic [PosW-1:0] found, input logic [DataW-1:0] rv);
    list_row_t row;
    row.op           = op;
    row.value        = value;
    row.pos          = pos;
    row.typed        = typed;
    row.want.status  = st;
    row.want.count   = cnt;
    row.want.found   = found;
    row.want.value   = rv;
    directed_rows.push_back(row);
  endtask

  // Hold the request until accepted, then log its expected result and, for a nonzero gap, drop start and idle.
  task automatic send_request(input logic [OpW-1:0] op, input logic [DataW-1:0] value,
                              input logic [PosW-1:0] pos, input logic typed,
                              input list_result_t want, input int unsigned gap);
    list_result_t predicted;
    start        <= 1'b1;
    operation_i  <= op;
    item_value_i <= value;
    position_i   <= pos;
    do @(posedge clk_i); while (busy);
    predicted = apply_list_op(op, value, pos);
    pending_results.push_back(typed ? want : predicted);
    request_count++;
    if (op == OP_SEARCH && predicted.status == ST_OK) hit_count++;
    if (predicted.status == ST_FULL) full_count++;
    if (predicted.status == ST_RANGE) range_count++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic report_field(input string name, input logic [DataW-1:0] want,
                              input logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d count %0d",
                 $time, status_o, entry_count_o);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        report_field("status", oldest_result.status, status_o);
        report_field("entry_count", oldest_result.count, entry_count_o);
        report_field("found_position", oldest_result.found, found_position_o);
        report_field("read_value", oldest_result.value, read_value_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("** positional_list_engine: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned mode;
    int unsigned r;
    int unsigned gap;
    int unsigned directed_count;
    logic [OpW-1:0]   op;
    logic [DataW-1:0] value;
    logic [PosW-1:0]  pos;

    error_count   = 0;
    cycle_count   = 0;
    request_count = 0;
    hit_count     = 0;
    full_count    = 0;
    range_count   = 0;
    shadow_len    = 0;
    mode          = 0;
    start        <= 1'b0;
    operation_i  <= OP_COUNT;
    item_value_i <= '0;
    position_i   <= '0;
    rst_ni       <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    add_row(OP_COUNT,      32'd0,         5'd0, 1'b1, ST_EMPTY,   5'd0, 5'd0, 32'd0);
    add_row(OP_DELETE_AT,  32'd0,         5'd1, 1'b1, ST_EMPTY,   5'd0, 5'd0, 32'd0);
    add_row(OP_SEARCH,     32'd0,         5'd0, 1'b1, ST_EMPTY,   5'd0, 5'd0, 32'd0);
    add_row(OP_READ_AT,    32'd0,         5'd1, 1'b1, ST_EMPTY,   5'd0, 5'd0, 32'd0);
    add_row(OP_INSERT_AT,  32'd1,         5'd0, 1'b1, ST_RANGE,   5'd0, 5'd0, 32'd0);
    add_row(OP_INSERT_AT,  32'd1,         5'd2, 1'b1, ST_RANGE,   5'd0, 5'd0, 32'd0);
    add_row(OP_INSERT_AT,  32'h7FFF_FFFF, 5'd1, 1'b1, ST_OK,      5'd1, 5'd0, 32'd0);
    add_row(OP_PUSH_FRONT, 32'h8000_0000, 5'd0, 1'b1, ST_OK,      5'd2, 5'd0, 32'd0);
    add_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 5'd0, 1'b1, ST_OK,      5'd3, 5'd0, 32'd0);
    add_row(OP_READ_AT,    32'd0,         5'd1, 1'b1, ST_OK,      5'd3, 5'd0, 32'h8000_0000);
    add_row(OP_READ_AT,    32'd0,         5'd3, 1'b0, ST_OK,      5'd0, 5'd0, 32'd0);
    add_row(OP_READ_AT,    32'd0,         5'd4, 1'b1, ST_RANGE,   5'd3, 5'd0, 32'd0);
    add_row(OP_READ_AT,    32'd0,         5'd0, 1'b1, ST_RANGE,   5'd3, 5'd0, 32'd0);
    add_row(OP_SEARCH,     32'hFFFF_FFFF, 5'd0, 1'b0, ST_OK,      5'd0, 5'd0, 32'd0);
    add_row(OP_SEARCH,     32'd12345,     5'd0, 1'b1, ST_MISSING, 5'd3, 5'd0, 32'd0);
    add_row(OP_INSERT_AT,  32'd5,         5'd3, 1'b0, ST_OK,      5'd0, 5'd0, 32'd0);
    add_row(OP_INSERT_AT,  32'd6,         5'd5, 1'b1, ST_RANGE,   5'd4, 5'd0, 32'd0);
    add_row(OP_DELETE_AT,  32'd0,         5'd0, 1'b1, ST_RANGE,   5'd4, 5'd0, 32'd0);
    add_row(OP_DELETE_AT,  32'd0,         5'd5, 1'b1, ST_RANGE,   5'd4, 5'd0, 32'd0);
    add_row(OP_DELETE_AT,  32'd0,         5'd4, 1'b0, ST_OK,      5'd0, 5'd0, 32'd0);
    add_row(OP_DELETE_AT,  32'd0,         5'd1, 1'b0, ST_OK,      5'd0, 5'd0, 32'd0);
    add_row(OP_UNUSED,     32'd9,         5'd3, 1'b0, ST_OK,      5'd0, 5'd0, 32'd0);
    add_row(OP_SEARCH,     32'h7FFF_FFFF, 5'd0, 1'b0, ST_OK,      5'd0, 5'd0, 32'd0);
    add_row(OP_COUNT,      32'd0,         5'd0, 1'b0, ST_OK,      5'd0, 5'd0, 32'd0);

    directed_count = directed_rows.size();
    foreach (directed_rows[n]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      send_request(directed_rows[n].op, directed_rows[n].value, directed_rows[n].pos,
                   directed_rows[n].typed, directed_rows[n].want, gap);
    end

    // Alternate fill-heavy, drain-heavy and mixed stretches so the list swings from empty to full.
    for (i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < ((mode == 0) ? 70 : (mode == 1) ? 15 : 35)) begin
        case ($urandom_range(0, 2))
          0:       op = OP_PUSH_FRONT;
          1:       op = OP_PUSH_BACK;
          default: op = OP_INSERT_AT;
        endcase
      end else if (r < ((mode == 0) ? 80 : (mode == 1) ? 75 : 60)) begin
        op = OP_DELETE_AT;
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_COUNT;
          1:       op = OP_SEARCH;
          default: op = OP_READ_AT;
        endcase
      end
      if ($urandom_range(0, 99) == 0) op = OP_UNUSED;

      if (op == OP_SEARCH && shadow_len > 0 && $urandom_range(0, 9) < 6)
        value = shadow_list[$urandom_range(0, shadow_len - 1)];
      else
        value = pick_value();

      case ($urandom_range(0, 9))
        0:       pos = '0;
        1:       pos = PosW'((shadow_len >= Capacity) ? Capacity : shadow_len + 1);
        2:       pos = PosW'($urandom_range(0, Capacity));
        3:       pos = PosW'(1);
        4:       pos = PosW'((shadow_len == 0) ? Capacity : shadow_len);
        default: pos = PosW'($urandom_range(1, (shadow_len == 0) ? 1 : shadow_len));
      endcase

      gap = (i >= RandomItems - CalmTail || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 12);
      send_request(op, value, pos, 1'b0, '0, gap);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d list requests (%0d from the directed table), %0d search hits,",
             request_count, directed_count, hit_count);
    $display("%0d inserts refused on a full list, %0d out-of-range positions, %0d mismatches.",
             full_count, range_count, error_count);
    if (error_count == 0) begin
      $display("** positional_list_engine: PASSED **");
    end else begin
      $display("** positional_list_engine: FAILED **");
    end
    $finish;
  end

endmodule
